/* design/nsd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nsd_pkg
// Shared widths, types and codes for the nearest segment direction search.
// ----------------------------------------------------------------------------
package nsd_pkg;

  localparam int CW      = 20;            // coordinate width
  localparam int DW      = CW + 1;        // coordinate difference width
  localparam int MW      = DW + 1;        // multiplier operand width (signed)
  localparam int PROD_W  = 2 * MW;        // multiplier product width
  localparam int ACC_W   = 2 * CW + 4;    // accumulator width
  localparam int DIST_W  = 2 * CW + 4;    // squared distance width
  localparam int LEN_W   = 2 * DW;        // squared length / cross magnitude width
  localparam int HALF_W  = LEN_W / 2;     // half of the cross magnitude width
  localparam int NUM_W   = 2 * LEN_W;     // dividend width
  localparam int QUO_W   = DIST_W;        // quotient bits produced
  localparam int REM_W   = LEN_W + 1;     // divider partial remainder width
  localparam int CNT_W   = $clog2(QUO_W);
  localparam int FRAC    = 14;            // direction fraction bits
  localparam int OUT_W   = 16;            // direction output width
  localparam int SRCH_W  = FRAC + 1;      // holds 0 .. 2^FRAC
  localparam int DIR_SHIFT = 2 * FRAC + 2;

  localparam logic signed [OUT_W-1:0] DIR_ONE = OUT_W'(1 << FRAC);
  localparam logic [SRCH_W-1:0]       SRCH_TOP = SRCH_W'(1 << FRAC);

  // one classified segment request in the queue
  typedef struct packed {
    logic signed [DW-1:0] vx;
    logic signed [DW-1:0] vy;
    logic signed [DW-1:0] wx;
    logic signed [DW-1:0] wy;
    logic signed [DW-1:0] ux;
    logic signed [DW-1:0] uy;
    logic                 degen;
    logic                 first;
    logic                 last;
  } seg_t;

  // divider request and response
  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [LEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHK,
    ST_CSQ,
    ST_DIVS,
    ST_DIV,
    ST_UPD,
    ST_MSQ,
    ST_SRCH,
    ST_EMIT
  } state_t;

  // product steps of the shared multiplier
  typedef enum logic [3:0] {
    MS_C1A,
    MS_C1B,
    MS_C2A,
    MS_C2B,
    MS_CRA,
    MS_CRB,
    MS_E0A,
    MS_E0B,
    MS_E1A,
    MS_E1B,
    CS_HH,
    CS_HL,
    CS_LL
  } step_t;

endpackage
`default_nettype wire

/* design/nsd_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nsd_if
// Valid/ready channels for segment requests and direction results.
// ----------------------------------------------------------------------------
interface nsd_in_if;
  logic                          valid;
  logic                          ready;
  logic signed [nsd_pkg::CW-1:0] query_x;
  logic signed [nsd_pkg::CW-1:0] query_y;
  logic signed [nsd_pkg::CW-1:0] start_x;
  logic signed [nsd_pkg::CW-1:0] start_y;
  logic signed [nsd_pkg::CW-1:0] end_x;
  logic signed [nsd_pkg::CW-1:0] end_y;
  logic                          first_segment;
  logic                          last_segment;

  modport source (output valid, query_x, query_y, start_x, start_y, end_x, end_y,
                  first_segment, last_segment, input ready);
  modport sink (input valid, query_x, query_y, start_x, start_y, end_x, end_y,
                first_segment, last_segment, output ready);
endinterface

interface nsd_out_if;
  logic                             valid;
  logic                             ready;
  logic                             found;
  logic signed [nsd_pkg::OUT_W-1:0] direction_x;
  logic signed [nsd_pkg::OUT_W-1:0] direction_y;

  modport source (output valid, found, direction_x, direction_y, input ready);
  modport sink (input valid, found, direction_x, direction_y, output ready);
endinterface
`default_nettype wire

/* design/nsd_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nsd_front
// Accepts segment requests, forms the difference vectors and flags
// zero-length segments before they enter the queue.
// ----------------------------------------------------------------------------
module nsd_front (
  nsd_in_if.sink          in_seg,
  output logic            push_valid,
  input  logic            push_ready,
  output nsd_pkg::seg_t   push_data
);

  logic signed [nsd_pkg::DW-1:0] vx, vy;

  // difference vectors, sign extended one bit
  always_comb begin
    vx = nsd_pkg::DW'(in_seg.end_x) - nsd_pkg::DW'(in_seg.start_x);
    vy = nsd_pkg::DW'(in_seg.end_y) - nsd_pkg::DW'(in_seg.start_y);
    push_data.vx    = vx;
    push_data.vy    = vy;
    push_data.wx    = nsd_pkg::DW'(in_seg.query_x) - nsd_pkg::DW'(in_seg.start_x);
    push_data.wy    = nsd_pkg::DW'(in_seg.query_y) - nsd_pkg::DW'(in_seg.start_y);
    push_data.ux    = nsd_pkg::DW'(in_seg.query_x) - nsd_pkg::DW'(in_seg.end_x);
    push_data.uy    = nsd_pkg::DW'(in_seg.query_y) - nsd_pkg::DW'(in_seg.end_y);
    push_data.degen = (vx == '0) && (vy == '0);
    push_data.first = in_seg.first_segment;
    push_data.last  = in_seg.last_segment;
  end

  assign push_valid   = in_seg.valid;
  assign in_seg.ready = push_ready;

endmodule
`default_nettype wire

/* design/nsd_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nsd_fifo
// Two-entry queue of classified segment requests between front and back.
// ----------------------------------------------------------------------------
module nsd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  nsd_pkg::seg_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output nsd_pkg::seg_t pop_data
);

  nsd_pkg::seg_t mem_r [2];
  logic          wr_ptr_r, rd_ptr_r;
  logic [1:0]    count_r;
  logic          do_push, do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      if (do_push && !do_pop)      count_r <= count_r + 2'd1;
      else if (do_pop && !do_push) count_r <= count_r - 2'd1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule
`default_nettype wire

/* design/nsd_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nsd_div
// Restoring divider, one quotient bit per cycle. The caller guarantees the
// quotient fits in QUO_W bits.
// ----------------------------------------------------------------------------
module nsd_div (
  input  logic              clk,
  input  logic              rst_n,
  input  nsd_pkg::div_req_t req,
  output nsd_pkg::div_rsp_t rsp
);

  logic [nsd_pkg::REM_W-1:0] rem_r;
  logic [nsd_pkg::QUO_W-1:0] quo_r;
  logic [nsd_pkg::LEN_W-1:0] den_r;
  logic [nsd_pkg::CNT_W-1:0] cnt_r;
  logic                      busy_r, done_r;
  logic [nsd_pkg::REM_W-1:0] trial;
  logic                      fits;

  // shift in the next dividend bit and try a subtract
  always_comb begin
    trial = {rem_r[nsd_pkg::REM_W-2:0], quo_r[nsd_pkg::QUO_W-1]};
    fits  = (trial >= nsd_pkg::REM_W'(den_r));
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == nsd_pkg::CNT_W'(nsd_pkg::QUO_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= nsd_pkg::REM_W'(req.num[nsd_pkg::NUM_W-1:nsd_pkg::QUO_W]);
      quo_r <= req.num[nsd_pkg::QUO_W-1:0];
      den_r <= req.den;
    end else if (busy_r) begin
      rem_r <= fits ? trial - nsd_pkg::REM_W'(den_r) : trial;
      quo_r <= {quo_r[nsd_pkg::QUO_W-2:0], fits};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule
`default_nettype wire

/* design/nsd_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nsd_back
// Sequencer over one shared multiplier and the divider: distance per
// segment, best-match tracking and the unit direction on the last segment.
// ----------------------------------------------------------------------------
module nsd_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  nsd_pkg::seg_t pop_data,
  nsd_out_if.source     out_res
);

  nsd_pkg::state_t state_r, state_nxt;
  nsd_pkg::step_t  step_r;
  nsd_pkg::seg_t   cur_r;

  logic signed [nsd_pkg::ACC_W-1:0]  c1_r, c2_r, cr_r, e0_r, e1_r;
  logic [nsd_pkg::NUM_W-1:0]         num_r;
  logic [nsd_pkg::LEN_W-1:0]         den_r;
  logic [nsd_pkg::DIST_W-1:0]        d_r, best_d_r;
  logic signed [nsd_pkg::DW-1:0]     best_dx_r, best_dy_r;
  logic [nsd_pkg::LEN_W-1:0]         best_c2_r;
  logic                              have_r, comp_r, dirmode_r;
  logic [nsd_pkg::SRCH_W-1:0]        lo_r, hi_r;
  logic signed [nsd_pkg::OUT_W-1:0]  dirx_r, diry_r;
  logic                              out_valid_r, out_found_r;
  logic signed [nsd_pkg::OUT_W-1:0]  out_dx_r, out_dy_r;

  logic signed [nsd_pkg::MW-1:0]     ma, mb;
  logic signed [nsd_pkg::PROD_W-1:0] prod;
  logic [nsd_pkg::PROD_W-1:0]        prod_u;
  logic [nsd_pkg::ACC_W-1:0]         cr_abs;
  logic [nsd_pkg::LEN_W-1:0]         crm;
  logic signed [nsd_pkg::DW-1:0]     bd;
  logic [nsd_pkg::DW-1:0]            bd_mag;
  logic [nsd_pkg::SRCH_W:0]          mid_sum;
  logic [nsd_pkg::SRCH_W-1:0]        mid;
  logic [nsd_pkg::SRCH_W:0]          tval;
  logic                              better, have_now, out_free, emit_go;
  logic signed [nsd_pkg::OUT_W-1:0]  comp_val;
  nsd_pkg::div_req_t                 div_req;
  nsd_pkg::div_rsp_t                 div_rsp;

  nsd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // helper values
  always_comb begin
    cr_abs  = cr_r[nsd_pkg::ACC_W-1] ? nsd_pkg::ACC_W'(-cr_r) : nsd_pkg::ACC_W'(cr_r);
    crm     = cr_abs[nsd_pkg::LEN_W-1:0];
    bd      = comp_r ? best_dy_r : best_dx_r;
    bd_mag  = bd[nsd_pkg::DW-1] ? nsd_pkg::DW'(-bd) : nsd_pkg::DW'(bd);
    mid_sum = {1'b0, lo_r} + {1'b0, hi_r} + 1'b1;
    mid     = mid_sum[nsd_pkg::SRCH_W:1];
    tval    = {mid, 1'b0} - 1'b1;
    better  = (d_r < best_d_r);
    out_free = !out_valid_r || out_res.ready;
  end

  // shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    case (state_r)
      nsd_pkg::ST_MUL: begin
        case (step_r)
          nsd_pkg::MS_C1A: begin ma = cur_r.wx; mb = cur_r.vx; end
          nsd_pkg::MS_C1B: begin ma = cur_r.wy; mb = cur_r.vy; end
          nsd_pkg::MS_C2A: begin ma = cur_r.vx; mb = cur_r.vx; end
          nsd_pkg::MS_C2B: begin ma = cur_r.vy; mb = cur_r.vy; end
          nsd_pkg::MS_CRA: begin ma = cur_r.wx; mb = cur_r.vy; end
          nsd_pkg::MS_CRB: begin ma = cur_r.wy; mb = cur_r.vx; end
          nsd_pkg::MS_E0A: begin ma = cur_r.wx; mb = cur_r.wx; end
          nsd_pkg::MS_E0B: begin ma = cur_r.wy; mb = cur_r.wy; end
          nsd_pkg::MS_E1A: begin ma = cur_r.ux; mb = cur_r.ux; end
          nsd_pkg::MS_E1B: begin ma = cur_r.uy; mb = cur_r.uy; end
          default: begin ma = '0; mb = '0; end
        endcase
      end
      nsd_pkg::ST_CSQ: begin
        case (step_r)
          nsd_pkg::CS_HH: begin
            ma = {1'b0, crm[nsd_pkg::LEN_W-1:nsd_pkg::HALF_W]};
            mb = {1'b0, crm[nsd_pkg::LEN_W-1:nsd_pkg::HALF_W]};
          end
          nsd_pkg::CS_HL: begin
            ma = {1'b0, crm[nsd_pkg::LEN_W-1:nsd_pkg::HALF_W]};
            mb = {1'b0, crm[nsd_pkg::HALF_W-1:0]};
          end
          default: begin
            ma = {1'b0, crm[nsd_pkg::HALF_W-1:0]};
            mb = {1'b0, crm[nsd_pkg::HALF_W-1:0]};
          end
        endcase
      end
      nsd_pkg::ST_MSQ: begin
        ma = {1'b0, bd_mag};
        mb = {1'b0, bd_mag};
      end
      nsd_pkg::ST_SRCH: begin
        ma = nsd_pkg::MW'(tval);
        mb = nsd_pkg::MW'(tval);
      end
      default: begin ma = '0; mb = '0; end
    endcase
    prod   = ma * mb;
    prod_u = nsd_pkg::PROD_W'(prod);
  end

  // next state and handshakes
  always_comb begin
    state_nxt = state_r;
    pop_ready = 1'b0;
    have_now  = have_r;
    emit_go   = 1'b0;
    div_req.start = (state_r == nsd_pkg::ST_DIVS);
    div_req.num   = num_r;
    div_req.den   = den_r;
    case (state_r)
      nsd_pkg::ST_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          have_now = pop_data.first ? 1'b0 : have_r;
          if (!pop_data.degen)    state_nxt = nsd_pkg::ST_MUL;
          else if (!pop_data.last) state_nxt = nsd_pkg::ST_IDLE;
          else if (have_now)       state_nxt = nsd_pkg::ST_MSQ;
          else                     state_nxt = nsd_pkg::ST_EMIT;
        end
      end
      nsd_pkg::ST_MUL: begin
        if (step_r == nsd_pkg::MS_E1B) state_nxt = nsd_pkg::ST_CHK;
      end
      nsd_pkg::ST_CHK: begin
        if (c1_r <= 0 || c1_r >= c2_r) state_nxt = nsd_pkg::ST_UPD;
        else                            state_nxt = nsd_pkg::ST_CSQ;
      end
      nsd_pkg::ST_CSQ: begin
        if (step_r == nsd_pkg::CS_LL) state_nxt = nsd_pkg::ST_DIVS;
      end
      nsd_pkg::ST_DIVS: state_nxt = nsd_pkg::ST_DIV;
      nsd_pkg::ST_DIV: begin
        if (div_rsp.done) state_nxt = dirmode_r ? nsd_pkg::ST_SRCH : nsd_pkg::ST_UPD;
      end
      nsd_pkg::ST_UPD: begin
        have_now = have_r || better;
        if (!cur_r.last)   state_nxt = nsd_pkg::ST_IDLE;
        else if (have_now) state_nxt = nsd_pkg::ST_MSQ;
        else               state_nxt = nsd_pkg::ST_EMIT;
      end
      nsd_pkg::ST_MSQ: state_nxt = nsd_pkg::ST_DIVS;
      nsd_pkg::ST_SRCH: begin
        if (lo_r >= hi_r) state_nxt = comp_r ? nsd_pkg::ST_EMIT : nsd_pkg::ST_MSQ;
      end
      nsd_pkg::ST_EMIT: begin
        emit_go = out_free;
        if (out_free) state_nxt = nsd_pkg::ST_IDLE;
      end
      default: state_nxt = nsd_pkg::ST_IDLE;
    endcase
  end

  // signed direction component from the search result
  assign comp_val = bd[nsd_pkg::DW-1] ? -nsd_pkg::OUT_W'(lo_r) : nsd_pkg::OUT_W'(lo_r);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nsd_pkg::ST_IDLE;
      best_d_r    <= '1;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == nsd_pkg::ST_IDLE && pop_valid && pop_data.first) begin
        best_d_r <= '1;
        have_r   <= 1'b0;
      end
      if (state_r == nsd_pkg::ST_UPD && better) begin
        best_d_r <= d_r;
        have_r   <= 1'b1;
      end
      if (emit_go)                out_valid_r <= 1'b1;
      else if (out_res.ready)     out_valid_r <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      nsd_pkg::ST_IDLE: begin
        cur_r  <= pop_data;
        step_r <= nsd_pkg::MS_C1A;
        comp_r <= 1'b0;
      end
      nsd_pkg::ST_MUL: begin
        step_r <= nsd_pkg::step_t'(step_r + 1'b1);
        case (step_r)
          nsd_pkg::MS_C1A: c1_r <= prod;
          nsd_pkg::MS_C1B: c1_r <= c1_r + prod;
          nsd_pkg::MS_C2A: c2_r <= prod;
          nsd_pkg::MS_C2B: c2_r <= c2_r + prod;
          nsd_pkg::MS_CRA: cr_r <= prod;
          nsd_pkg::MS_CRB: cr_r <= cr_r - prod;
          nsd_pkg::MS_E0A: e0_r <= prod;
          nsd_pkg::MS_E0B: e0_r <= e0_r + prod;
          nsd_pkg::MS_E1A: e1_r <= prod;
          default:         e1_r <= e1_r + prod;
        endcase
      end
      nsd_pkg::ST_CHK: begin
        step_r    <= nsd_pkg::CS_HH;
        dirmode_r <= 1'b0;
        den_r     <= c2_r[nsd_pkg::LEN_W-1:0];
        if (c1_r <= 0)          d_r <= nsd_pkg::DIST_W'(e0_r);
        else if (c1_r >= c2_r) d_r <= nsd_pkg::DIST_W'(e1_r);
      end
      nsd_pkg::ST_CSQ: begin
        step_r <= nsd_pkg::step_t'(step_r + 1'b1);
        case (step_r)
          nsd_pkg::CS_HH: num_r <= nsd_pkg::NUM_W'(prod_u) << (2 * nsd_pkg::HALF_W);
          nsd_pkg::CS_HL: num_r <= num_r + (nsd_pkg::NUM_W'(prod_u) << (nsd_pkg::HALF_W + 1));
          default:        num_r <= num_r + nsd_pkg::NUM_W'(prod_u);
        endcase
      end
      nsd_pkg::ST_DIV: begin
        if (div_rsp.done) d_r <= div_rsp.quo;
      end
      nsd_pkg::ST_UPD: begin
        if (better) begin
          best_dx_r <= cur_r.vx;
          best_dy_r <= cur_r.vy;
          best_c2_r <= c2_r[nsd_pkg::LEN_W-1:0];
        end
      end
      nsd_pkg::ST_MSQ: begin
        num_r     <= nsd_pkg::NUM_W'(prod_u) << nsd_pkg::DIR_SHIFT;
        den_r     <= best_c2_r;
        dirmode_r <= 1'b1;
        lo_r      <= '0;
        hi_r      <= nsd_pkg::SRCH_TOP;
      end
      nsd_pkg::ST_SRCH: begin
        if (lo_r < hi_r) begin
          if (nsd_pkg::DIST_W'(prod_u) <= d_r) lo_r <= mid;
          else                                 hi_r <= mid - 1'b1;
        end else begin
          comp_r <= 1'b1;
          if (comp_r) diry_r <= comp_val;
          else        dirx_r <= comp_val;
        end
      end
      nsd_pkg::ST_EMIT: begin
        if (out_free) begin
          out_found_r <= have_r;
          out_dx_r    <= have_r ? dirx_r : nsd_pkg::DIR_ONE;
          out_dy_r    <= have_r ? diry_r : '0;
        end
      end
      default: ;
    endcase
  end

  assign out_res.valid       = out_valid_r;
  assign out_res.found       = out_found_r;
  assign out_res.direction_x = out_dx_r;
  assign out_res.direction_y = out_dy_r;

endmodule
`default_nettype wire

/* design/nearest_segment_direction.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_segment_direction
// Nearest-segment search for a query point with unit direction result.
// ----------------------------------------------------------------------------
// Usage:
//   in_seg carries one segment request per handshake: query point, segment
//   endpoints and the first/last marks of a search. out_res carries one
//   result per request marked last: found flag and the Q1.14 unit direction
//   of the closest non-degenerate segment, or (1,0) when none qualified.
//   A two-entry queue sits behind the input, so requests are taken while
//   the sequencer is busy, until the queue fills.
// Sequence:
//   All products go through one shared multiplier, and the divider yields
//   one quotient bit per cycle. A zero-length segment is only taken from
//   the queue; a segment whose projection lands on an endpoint runs the
//   product steps, and an inner projection adds the cross square and a
//   division. A last request with a kept match adds two divisions, two root
//   searches and the emit; without a kept match it only emits.
// Reset and stalls:
//   Reset clears the queue, the kept match and the output register. If the
//   receiver stalls, the result waits in the output register and the
//   sequencer holds before emitting the next one; the queue keeps filling.
// ----------------------------------------------------------------------------
module nearest_segment_direction (
  input  logic       clk,
  input  logic       rst_n,
  nsd_in_if.sink     in_seg,
  nsd_out_if.source  out_res
);

  logic          push_valid, push_ready, pop_valid, pop_ready;
  nsd_pkg::seg_t push_data, pop_data;

  nsd_front u_front (
    .in_seg     (in_seg),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  nsd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  nsd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_res   (out_res)
  );

endmodule
`default_nettype wire

/* tb/tb_nearest_segment_direction.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nearest_segment_direction
// Self-checking bench for the nearest segment direction search.
// ----------------------------------------------------------------------------
// A queue of segment requests is filled up front: a directed set covering
// extreme coordinates, clamping on either end, inner projections, zero-length
// segments, ties and flag combinations, then random searches. A clocked
// driver presents them with random gaps, a clocked monitor accepts results
// under random back-pressure, and each accepted request is run through a
// bench-side model of the search to predict the direction result.
// ----------------------------------------------------------------------------
module tb_nearest_segment_direction;

  localparam int CLK_LIMIT = 4000000;
  localparam int DRAIN_CYCLES = 400;
  localparam longint CMAX = 524287;
  localparam longint CMIN = -524288;

  typedef struct {
    longint qx, qy, sx, sy, ex, ey;
    bit     first, last;
  } seg_req_t;

  typedef struct {
    logic                      found;
    logic [nsd_pkg::OUT_W-1:0] dir_x;
    logic [nsd_pkg::OUT_W-1:0] dir_y;
  } dir_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  nsd_in_if  in_seg ();
  nsd_out_if out_res ();

  nearest_segment_direction u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_seg  (in_seg),
    .out_res (out_res)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  seg_req_t pending_reqs[$];
  dir_res_t expected_dirs[$];
  bit       stim_done = 1'b0;
  bit       in_fire_q = 1'b0;
  int       fail_count = 0;
  int       req_count = 0;
  int       res_count = 0;
  int       found_count = 0;
  int       cycle_count = 0;

  // search state kept alongside the block
  logic [127:0] best_dist_sq;
  longint       best_dx, best_dy;
  bit           best_valid;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic longint sq_len(longint x, longint y);
    return x * x + y * y;
  endfunction

  // squared point-to-segment distance, projection clamped to the ends
  function automatic logic [127:0] seg_dist_sq(seg_req_t r);
    longint vx, vy, wx, wy, dot, len2, cr;
    logic [127:0] crm;
    vx = r.ex - r.sx;
    vy = r.ey - r.sy;
    wx = r.qx - r.sx;
    wy = r.qy - r.sy;
    dot = wx * vx + wy * vy;
    len2 = sq_len(vx, vy);
    if (dot <= 0) return 128'(sq_len(wx, wy));
    if (dot >= len2) return 128'(sq_len(r.qx - r.ex, r.qy - r.ey));
    cr = wx * vy - wy * vx;
    if (cr < 0) cr = -cr;
    crm = 128'(cr);
    return (crm * crm) / 128'(len2);
  endfunction

  // rounded Q1.14 component by search on (2k-1)^2 * len2 <= (2m)^2 << 28
  function automatic logic [nsd_pkg::OUT_W-1:0] unit_comp(longint delta, longint len2);
    logic [127:0] target, t;
    longint m, lo, hi, mid;
    m = (delta < 0) ? -delta : delta;
    target = (128'(m) * 128'(m)) << nsd_pkg::DIR_SHIFT;
    lo = 0;
    hi = longint'(1) << nsd_pkg::FRAC;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      t = 128'(2 * mid - 1);
      if (128'(len2) * t * t <= target) lo = mid;
      else hi = mid - 1;
    end
    return nsd_pkg::OUT_W'((delta < 0) ? -lo : lo);
  endfunction

  function automatic void clear_search();
    best_dist_sq = (128'(1) << nsd_pkg::DIST_W) - 1;
    best_dx = 0;
    best_dy = 0;
    best_valid = 1'b0;
  endfunction

  function automatic void predict_search(seg_req_t r);
    logic [127:0] d;
    dir_res_t res;
    if (r.first) clear_search();
    if (r.ex != r.sx || r.ey != r.sy) begin
      d = seg_dist_sq(r);
      if (d < best_dist_sq) begin
        best_dist_sq = d;
        best_dx = r.ex - r.sx;
        best_dy = r.ey - r.sy;
        best_valid = 1'b1;
      end
    end
    if (!r.last) return;
    res.found = best_valid;
    if (best_valid) begin
      res.dir_x = unit_comp(best_dx, sq_len(best_dx, best_dy));
      res.dir_y = unit_comp(best_dy, sq_len(best_dx, best_dy));
    end else begin
      res.dir_x = nsd_pkg::DIR_ONE;
      res.dir_y = '0;
    end
    expected_dirs = {expected_dirs, res};
  endfunction

  function automatic longint wrap_coord(longint v);
    logic signed [nsd_pkg::CW-1:0] c;
    c = nsd_pkg::CW'(v);
    return longint'(c);
  endfunction

  function automatic longint rand_coord(longint base);
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return CMAX;
    if (r == 1) return CMIN;
    if (r < 5) return wrap_coord(longint'($urandom()));
    if (r < 11) return wrap_coord(base + $urandom_range(0, 4000) - 2000);
    return wrap_coord(base + $urandom_range(0, 40) - 20);
  endfunction

  function automatic void add_req(longint qx, longint qy, longint sx, longint sy,
                                  longint ex, longint ey, bit first, bit last);
    seg_req_t r;
    r.qx = qx; r.qy = qy; r.sx = sx; r.sy = sy; r.ex = ex; r.ey = ey;
    r.first = first; r.last = last;
    pending_reqs = {pending_reqs, r};
  endfunction

  function automatic void add_rand_seg(longint base, bit first, bit last);
    longint sx, sy;
    sx = rand_coord(base);
    sy = rand_coord(base);
    if ($urandom_range(0, 9) == 0)
      add_req(rand_coord(base), rand_coord(base), sx, sy, sx, sy, first, last);
    else
      add_req(rand_coord(base), rand_coord(base), sx, sy, rand_coord(base),
              rand_coord(base), first, last);
  endfunction

  // stimulus: directed cases, then random searches with some noise
  initial begin
    int n, len;
    longint base;
    clear_search();
    // last without any first, from reset, zero-length only: not found
    add_req(5, 5, 7, 7, 7, 7, 1'b0, 1'b1);
    // both flags on one segment, inner projection
    add_req(0, 10, -10, 0, 10, 0, 1'b1, 1'b1);
    // projection before start, then exactly on the start point
    add_req(-50, 3, 0, 0, 16, 16, 1'b1, 1'b1);
    add_req(90, 90, 0, 0, 16, -16, 1'b1, 1'b1);
    // extreme coordinates, full-span segments
    add_req(CMAX, CMAX, CMIN, CMIN, CMAX, CMAX, 1'b1, 1'b1);
    add_req(CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, 1'b1, 1'b1);
    add_req(0, 0, CMIN, CMAX, CMAX, CMIN, 1'b1, 1'b1);
    add_req(CMAX, CMIN, CMIN, CMIN, CMIN, CMAX, 1'b1, 1'b1);
    // tie: reversed copy at the same distance must not replace
    add_req(3, 8, 0, 0, 20, 0, 1'b1, 1'b0);
    add_req(3, 8, 20, 0, 0, 0, 1'b0, 1'b0);
    add_req(3, 8, 2, 2, 2, 2, 1'b0, 1'b1);
    // closer segment later wins, degenerate in the middle
    add_req(0, 0, 100, -50, 100, 50, 1'b1, 1'b0);
    add_req(0, 0, 9, 9, 9, 9, 1'b0, 1'b0);
    add_req(0, 0, -30, 5, 30, 40, 1'b0, 1'b1);
    // last without first continues the previous kept match
    add_req(0, 0, 500, 500, 600, 600, 1'b0, 1'b1);
    // query on the segment, zero distance, then exact tie at zero
    add_req(4, 4, 0, 0, 8, 8, 1'b1, 1'b0);
    add_req(4, 4, 0, 8, 8, 0, 1'b0, 1'b1);
    // first without last, then a fresh search only of degenerates
    add_req(1, 1, 2, 3, 4, 5, 1'b1, 1'b0);
    add_req(1, 1, 2, 3, 2, 3, 1'b1, 1'b1);
    // odd direction rounding cases
    add_req(0, 0, 0, 0, 1, 2, 1'b1, 1'b1);
    add_req(0, 0, 0, 0, -3, 1, 1'b1, 1'b1);

    // random searches; about one in ten draws is a single item with random flags
    n = pending_reqs.size();
    while (n < 1900) begin
      base = $urandom_range(0, 1000000) - 500000;
      if ($urandom_range(0, 9) == 0) begin
        add_rand_seg(base, 1'($urandom()), 1'($urandom()));
        n++;
      end else begin
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++) add_rand_seg(base, k == 0, k == len - 1);
        n += len;
      end
    end
    stim_done = 1'b1;
  end

  // request driver, changes at the falling edge
  int  in_gap = 0;
  bit  in_calm = 1'b0;

  always @(negedge clk) begin
    seg_req_t r;
    if (!rst_n) begin
      in_seg.valid <= 1'b0;
    end else if (!in_seg.valid || in_fire_q) begin
      if ($urandom_range(0, 199) == 0) in_calm = !in_calm;
      if (in_gap > 0 || pending_reqs.size() == 0) begin
        if (in_gap > 0) in_gap--;
        in_seg.valid <= 1'b0;
      end else begin
        r = pending_reqs.pop_front();
        in_seg.query_x <= nsd_pkg::CW'(r.qx);
        in_seg.query_y <= nsd_pkg::CW'(r.qy);
        in_seg.start_x <= nsd_pkg::CW'(r.sx);
        in_seg.start_y <= nsd_pkg::CW'(r.sy);
        in_seg.end_x <= nsd_pkg::CW'(r.ex);
        in_seg.end_y <= nsd_pkg::CW'(r.ey);
        in_seg.first_segment <= r.first;
        in_seg.last_segment <= r.last;
        in_seg.valid <= 1'b1;
        in_gap = in_calm ? 0 : gap_len();
      end
    end
  end

  // result back-pressure
  int  out_stall = 0;

  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_stall--;
      out_res.ready <= 1'b0;
    end else begin
      out_res.ready <= 1'b1;
      out_stall = in_calm ? 0 : gap_len();
    end
  end

  initial begin
    in_seg.valid = 1'b0;
    in_seg.query_x = '0;
    in_seg.query_y = '0;
    in_seg.start_x = '0;
    in_seg.start_y = '0;
    in_seg.end_x = '0;
    in_seg.end_y = '0;
    in_seg.first_segment = 1'b0;
    in_seg.last_segment = 1'b0;
    out_res.ready = 1'b0;
  end

  // accepted requests feed the predictor
  always @(posedge clk) begin
    seg_req_t r;
    in_fire_q <= rst_n && in_seg.valid && in_seg.ready;
    if (rst_n && in_seg.valid && in_seg.ready) begin
      r.qx = in_seg.query_x; r.qy = in_seg.query_y;
      r.sx = in_seg.start_x; r.sy = in_seg.start_y;
      r.ex = in_seg.end_x; r.ey = in_seg.end_y;
      r.first = in_seg.first_segment;
      r.last = in_seg.last_segment;
      predict_search(r);
      req_count++;
    end
  end

  // result monitor
  always @(posedge clk) begin
    dir_res_t want;
    if (rst_n && out_res.valid && out_res.ready) begin
      res_count++;
      if (expected_dirs.size() == 0) begin
        $error("unexpected result: found=%0b dir=(%0d,%0d)", out_res.found,
               out_res.direction_x, out_res.direction_y);
        fail_count++;
      end else begin
        want = expected_dirs.pop_front();
        if (want.found) found_count++;
        if (out_res.found !== want.found) begin
          $error("found: expected %0b, got %0b", want.found, out_res.found);
          fail_count++;
        end
        if (out_res.direction_x !== want.dir_x) begin
          $error("direction_x: expected %0d, got %0d", $signed(want.dir_x),
                 out_res.direction_x);
          fail_count++;
        end
        if (out_res.direction_y !== want.dir_y) begin
          $error("direction_y: expected %0d, got %0d", $signed(want.dir_y),
                 out_res.direction_y);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CLK_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_dirs.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // reset, then wait for drain and report
  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    wait (stim_done);
    while (pending_reqs.size() != 0 || in_seg.valid || expected_dirs.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_dirs.size() != 0) begin
      $error("%0d expected results never arrived", expected_dirs.size());
      fail_count++;
    end
    $display("covered %0d segment requests, %0d results (%0d found), %0d cycles",
             req_count, res_count, found_count, cycle_count);
    $display("mismatches: %0d", fail_count);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* files.f */
design/nsd_pkg.sv
design/nsd_if.sv
design/nsd_front.sv
design/nsd_fifo.sv
design/nsd_div.sv
design/nsd_back.sv
design/nearest_segment_direction.sv
tb/tb_nearest_segment_direction.sv
